[hdl/sai_pkg.sv]
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types, field widths and codes for the signal area integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package sai_pkg;

  // Field widths
  localparam int X_W     = 32;
  localparam int Y_W     = 24;
  localparam int AREA_W  = 64;
  localparam int TOTAL_W = 48;
  localparam int COUNT_W = 21;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 2;

  // Multiplier operands: signed x difference or increment and signed y term
  localparam int OPA_W = X_W + 1;
  localparam int OPB_W = Y_W + 2;
  localparam int PROD_W = OPA_W + OPB_W;

  // Stream payload widths, padded to whole bytes
  localparam int S_DATA_W = ((X_W + Y_W + 7) / 8) * 8;
  localparam int M_BITS   = AREA_W + Y_W + TOTAL_W + Y_W + COUNT_W + 1;
  localparam int M_DATA_W = ((M_BITS + 7) / 8) * 8;

  // Divider: one quotient bit per step over the total magnitude
  localparam int DIV_STEPS = TOTAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Sample count field limit and default cap
  localparam int COUNT_FIELD_MAX = (1 << COUNT_W) - 1;
  localparam int MAX_SAMPLES_DEF = 1048576;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_AREA_MODE     = 3'd0;
  localparam logic [IDX_W-1:0] REG_X_INCREMENT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_ENABLE = 3'd2;
  localparam logic [IDX_W-1:0] REG_WINDOW_START  = 3'd3;
  localparam logic [IDX_W-1:0] REG_WINDOW_END    = 3'd4;

  // Area modes
  localparam logic [MODE_W-1:0] MODE_TRAPEZOID = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CONTOUR   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIXED_DX  = 2'd2;

  // Register reset values
  localparam logic [X_W-1:0] X_INCREMENT_RST = 32'h0001_0000;
  localparam logic [X_W-1:0] WINDOW_END_RST  = 32'hFFFF_FFFF;

  // Saturation limits
  localparam logic [Y_W-1:0]     Y_MIN_VAL     = 24'h80_0000;
  localparam logic [Y_W-1:0]     Y_MAX_VAL     = 24'h7F_FFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MIN_VAL = {1'b1, {(TOTAL_W-1){1'b0}}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX_VAL = {1'b0, {(TOTAL_W-1){1'b1}}};
  localparam logic [AREA_W-1:0]  AREA_MIN_VAL  = {1'b1, {(AREA_W-1){1'b0}}};
  localparam logic [AREA_W-1:0]  AREA_MAX_VAL  = {1'b0, {(AREA_W-1){1'b1}}};

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } sai_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic div_start;
    logic div_step;
    logic out_load;
  } sai_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last;
    logic out_free;
  } sai_stat_t;

endpackage

`default_nettype wire

[hdl/sai_ctrl.sv]
// ----------------------------------------------------------------------------
// sai_ctrl
// Sequencer: sample load, multiply, accumulate, then on the last sample a
// bit-serial divide and the result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_ctrl
  import sai_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  input  wire sai_stat_t stat,
  output sai_cmd_t       cmd
);

  sai_state_t           state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  // State and divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    div_cnt_next = '0;
    cmd          = '0;
    s_tready     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        if (stat.last) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          div_cnt_next = '0;
          state_next   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[hdl/sai_datapath.sv]
// ----------------------------------------------------------------------------
// sai_datapath
// Configuration registers, signal state, area multiplier and saturating
// accumulators, restoring divider for the average, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sai_datapath
  import sai_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic [S_DATA_W-1:0] s_tdata,
  input  wire logic                s_tlast,
  input  wire sai_cmd_t            cmd,
  output sai_stat_t                stat,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata
);

  localparam int COUNT_CAP_INT =
    (MAX_SAMPLES > COUNT_FIELD_MAX) ? COUNT_FIELD_MAX : MAX_SAMPLES;
  localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_INT);

  // Configuration registers
  logic [MODE_W-1:0] area_mode;
  logic [X_W-1:0]    x_increment;
  logic              window_enable;
  logic [X_W-1:0]    window_start;
  logic [X_W-1:0]    window_end;

  // Signal state
  logic [X_W-1:0]            prev_x;
  logic signed [Y_W-1:0]     prev_y;
  logic                      have_prev;
  logic [AREA_W-1:0]         area_acc;
  logic signed [Y_W-1:0]     peak_acc;
  logic [TOTAL_W-1:0]        total_acc;
  logic [COUNT_W-1:0]        count_acc;
  logic                      sat_flag;
  logic                      last_flag;

  // Multiplier pipeline
  logic signed [OPA_W-1:0]   op_a, op_a_next;
  logic signed [OPB_W-1:0]   op_b, op_b_next;
  logic signed [PROD_W-1:0]  product;

  // Divider
  logic [TOTAL_W-1:0]        div_q;
  logic [COUNT_W-1:0]        div_rem;
  logic                      div_neg;
  logic [COUNT_W:0]          div_trial;
  logic                      div_ge;

  // Sample fields
  logic [X_W-1:0]            x_in;
  logic signed [Y_W-1:0]     y_in;

  // Combinational terms
  logic signed [Y_W:0]       y_sum;
  logic signed [Y_W:0]       y_diff;
  logic [Y_W:0]              y_absd;
  logic signed [OPA_W-1:0]   dx;
  logic                      win_ok;
  logic [AREA_W-1:0]         addend;
  logic [AREA_W-1:0]         area_sum;
  logic                      area_ovf;
  logic [TOTAL_W:0]          total_sum;
  logic                      total_ovf;
  logic [Y_W-1:0]            avg;

  assign x_in = s_tdata[X_W-1:0];
  assign y_in = $signed(s_tdata[X_W+Y_W-1:X_W]);

  // Configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      area_mode     <= MODE_TRAPEZOID;
      x_increment   <= X_INCREMENT_RST;
      window_enable <= 1'b0;
      window_start  <= '0;
      window_end    <= WINDOW_END_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_AREA_MODE:     area_mode     <= cfg_data[MODE_W-1:0];
        REG_X_INCREMENT:   x_increment   <= cfg_data[X_W-1:0];
        REG_WINDOW_ENABLE: window_enable <= cfg_data[0];
        REG_WINDOW_START:  window_start  <= cfg_data[X_W-1:0];
        REG_WINDOW_END:    window_end    <= cfg_data[X_W-1:0];
        default: ;
      endcase
    end
  end

  // Multiplier operands for the step ending at this sample
  assign y_sum  = {y_in[Y_W-1], y_in} + {prev_y[Y_W-1], prev_y};
  assign y_diff = {y_in[Y_W-1], y_in} - {prev_y[Y_W-1], prev_y};
  assign y_absd = y_diff[Y_W] ? (~$unsigned(y_diff) + 1'b1) : $unsigned(y_diff);
  assign dx     = $signed({1'b0, x_in}) - $signed({1'b0, prev_x});
  assign win_ok = !window_enable || (area_mode == MODE_FIXED_DX) ||
                  ((x_in > window_start) && (x_in <= window_end));

  always_comb begin
    unique case (area_mode)
      MODE_TRAPEZOID: begin
        op_a_next = dx;
        op_b_next = {y_sum[Y_W], y_sum};
      end
      MODE_CONTOUR: begin
        op_a_next = dx;
        op_b_next = $signed({1'b0, y_absd});
      end
      MODE_FIXED_DX: begin
        op_a_next = $signed({1'b0, x_increment});
        op_b_next = {y_sum[Y_W], y_sum};
      end
      default: begin
        op_a_next = '0;
        op_b_next = '0;
      end
    endcase
    // No step on the first sample or outside the window
    if (!have_prev || !win_ok) begin
      op_a_next = '0;
    end
  end

  // Saturating adds
  assign addend    = {{(AREA_W-PROD_W){product[PROD_W-1]}}, product};
  assign area_sum  = area_acc + addend;
  assign area_ovf  = (area_acc[AREA_W-1] == addend[AREA_W-1]) &&
                     (area_sum[AREA_W-1] != area_acc[AREA_W-1]);
  assign total_sum = {total_acc[TOTAL_W-1], total_acc} +
                     {{(TOTAL_W+1-Y_W){y_in[Y_W-1]}}, y_in};
  assign total_ovf = total_sum[TOTAL_W] != total_sum[TOTAL_W-1];

  // Divider trial subtract
  assign div_trial = {div_rem, div_q[TOTAL_W-1]};
  assign div_ge    = div_trial >= {1'b0, count_acc};

  // Signed, clamped average from quotient magnitude
  always_comb begin
    if (div_neg) begin
      if (div_q > TOTAL_W'({1'b0, Y_MIN_VAL})) begin
        avg = Y_MIN_VAL;
      end else begin
        avg = ~div_q[Y_W-1:0] + 1'b1;
      end
    end else begin
      if (div_q > TOTAL_W'(Y_MAX_VAL)) begin
        avg = Y_MAX_VAL;
      end else begin
        avg = div_q[Y_W-1:0];
      end
    end
  end

  // Signal state, multiplier and accumulators
  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
      area_acc  <= '0;
      peak_acc  <= $signed(Y_MIN_VAL);
      total_acc <= '0;
      count_acc <= '0;
      sat_flag  <= 1'b0;
      last_flag <= 1'b0;
    end else begin
      // Take the sample: operands, peak, total, count
      if (cmd.load) begin
        op_a      <= op_a_next;
        op_b      <= op_b_next;
        prev_x    <= x_in;
        prev_y    <= y_in;
        have_prev <= 1'b1;
        last_flag <= s_tlast;
        if (y_in > peak_acc) begin
          peak_acc <= y_in;
        end
        if (total_ovf) begin
          total_acc <= total_sum[TOTAL_W] ? TOTAL_MIN_VAL : TOTAL_MAX_VAL;
        end else begin
          total_acc <= total_sum[TOTAL_W-1:0];
        end
        if (count_acc < COUNT_CAP) begin
          count_acc <= count_acc + 1'b1;
        end
        // Flag a saturated total or a count held at its cap
        if (total_ovf || (count_acc >= COUNT_CAP)) begin
          sat_flag <= 1'b1;
        end
      end
      // Multiply stage
      if (cmd.mul) begin
        product <= op_a * op_b;
      end
      // Accumulate stage
      if (cmd.acc) begin
        if (area_ovf) begin
          area_acc <= area_acc[AREA_W-1] ? AREA_MIN_VAL : AREA_MAX_VAL;
          sat_flag <= 1'b1;
        end else begin
          area_acc <= area_sum;
        end
      end
    end
  end

  // Restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q   <= total_acc[TOTAL_W-1] ? (~total_acc + 1'b1) : total_acc;
      div_rem <= '0;
      div_neg <= total_acc[TOTAL_W-1];
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? COUNT_W'(div_trial - {1'b0, count_acc})
                        : div_trial[COUNT_W-1:0];
      div_q   <= {div_q[TOTAL_W-2:0], div_ge};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= M_DATA_W'({sat_flag, count_acc, avg, total_acc, peak_acc,
                            area_acc[AREA_W-1], area_acc[AREA_W-1:1]});
    end
  end

  assign stat.last     = last_flag;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

[hdl/signal_area_integrator_top.sv]
// ----------------------------------------------------------------------------
// signal_area_integrator_top
// Integrates (x, y) sample streams into area, peak, total, average and count.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one (x, y) sample per transaction, s_tlast closes the
//   signal. Output stream m_*: one result transaction per closed signal.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 area_mode, 1 x_increment, 2 window_enable, 3 window_start,
//   4 window_end); write only while the block is idle.
//   Samples: each sample passes the load, multiply (33x26 multiplier) and
//   accumulate (64-bit saturating add) states before the next is taken.
//   Result: after the last sample of a signal, the bit-serial divider forms
//   the average over the 48-bit total magnitude, one quotient bit per cycle,
//   and the result is loaded once the output register is free.
//   Reset: synchronous rst restores the register defaults, clears the signal
//   state and drops any pending result.
//   Stall: the result waits in the output register while m_tready is low;
//   samples keep flowing until another result is ready to be handed over.
// ----------------------------------------------------------------------------
`default_nettype none

module signal_area_integrator_top
  import sai_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // Configuration write port
  input  wire logic                cfg_we,
  input  wire logic [IDX_W-1:0]    cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  // Sample stream
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // x_value[31:0], y_value[55:32]
  input  wire logic                s_tlast,  // last_sample
  // Result stream
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  // area[63:0], peak[87:64], total[135:88], average[159:136],
  // sample_count[180:160], overflow[181], zero pad[183:182]
  output logic [M_DATA_W-1:0]      m_tdata
);

  sai_cmd_t  cmd;
  sai_stat_t stat;

  sai_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sai_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cmd       (cmd),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

`default_nettype wire
